// ----- hw/rtl/stereo_to_surround_upmix_unit_macros.svh -----
`ifndef STEREO_TO_SURROUND_UPMIX_UNIT_MACROS_SVH
`define STEREO_TO_SURROUND_UPMIX_UNIT_MACROS_SVH

// cons must hold in the same cycle as ante
`define STSU_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// cons must hold in the cycle after ante
`define STSU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/stsu_pkg.sv -----
package stsu_pkg;

    localparam int TAPS        = 31;
    localparam int SAMPLE_BITS = 16;
    localparam int COEF_COUNT  = 31;
    localparam int Q_FRAC      = 15;
    localparam int COEF_W      = 16;

    localparam int TAP_W     = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int PROD_W    = COEF_W + SAMPLE_BITS;
    // sum of |lp coef| < 2^16, so the fir sum stays below 2^(SAMPLE_BITS+15)
    localparam int ACC_W     = SAMPLE_BITS + 18;
    localparam int ACC_N     = 8;
    localparam int ACC_IDX_W = 3;
    localparam int LANES     = 3;
    localparam int LANE_W    = 2;
    localparam int HIST_W    = LANES * SAMPLE_BITS;

    localparam int MTX_STEPS = 8;
    localparam int MTX_W     = 3;

    localparam int IN_FIELDS    = 2;
    localparam int OUT_FIELDS   = 6;
    localparam int IN_TDATA_W   = ((IN_FIELDS * SAMPLE_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS * SAMPLE_BITS + 7) / 8) * 8;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [COEF_W-1:0]      coef_t;
    typedef logic signed [PROD_W-1:0]      prod_t;
    typedef logic signed [ACC_W-1:0]       acc_t;
    typedef logic [ACC_IDX_W-1:0]          acc_idx_t;
    typedef logic [TAP_W-1:0]              tap_idx_t;
    typedef logic [LANE_W-1:0]             lane_t;
    typedef logic [HIST_W-1:0]             hist_word_t;

    // matrix constants, q1.15
    localparam coef_t K_FRONT = coef_t'(23167);
    localparam coef_t K_HALF  = coef_t'(16384);
    localparam coef_t K_MAJOR = coef_t'(18917);
    localparam coef_t K_MINOR = coef_t'(13373);

    // accumulator slots
    localparam acc_idx_t ACC_FL  = acc_idx_t'(0);
    localparam acc_idx_t ACC_FR  = acc_idx_t'(1);
    localparam acc_idx_t ACC_CN  = acc_idx_t'(2);
    localparam acc_idx_t ACC_LSN = acc_idx_t'(3);
    localparam acc_idx_t ACC_RSN = acc_idx_t'(4);
    localparam acc_idx_t ACC_CF  = acc_idx_t'(5);
    localparam acc_idx_t ACC_LSF = acc_idx_t'(6);
    localparam acc_idx_t ACC_RSF = acc_idx_t'(7);

    // lanes of one history word, lowest bits first
    localparam lane_t LANE_C  = lane_t'(0);
    localparam lane_t LANE_LS = lane_t'(1);
    localparam lane_t LANE_RS = lane_t'(2);

    localparam acc_t ROUND_BIAS = acc_t'(2 ** (Q_FRAC - 1));
    localparam acc_t SAT_HI     = acc_t'(2 ** (SAMPLE_BITS - 1) - 1);
    localparam acc_t SAT_LO     = acc_t'(-(2 ** (SAMPLE_BITS - 1)));

    typedef struct packed {
        coef_t    coef;
        logic     use_right;
        acc_idx_t dst;
    } mtx_entry_t;

    typedef struct packed {
        logic     clear;
        logic     valid;
        acc_idx_t dst;
        coef_t    coef;
        sample_t  operand;
    } mac_op_t;

    function automatic coef_t lp_coef(input tap_idx_t k);
        coef_t c;
        case (int'(k))
            0, 30:   c = coef_t'(5);
            1, 29:   c = coef_t'(28);
            2, 28:   c = coef_t'(26);
            3, 27:   c = coef_t'(-72);
            4, 26:   c = coef_t'(-211);
            5, 25:   c = coef_t'(-168);
            6, 24:   c = coef_t'(203);
            7, 23:   c = coef_t'(647);
            8, 22:   c = coef_t'(573);
            9, 21:   c = coef_t'(-355);
            10, 20:  c = coef_t'(-1563);
            11, 19:  c = coef_t'(-1670);
            12, 18:  c = coef_t'(475);
            13, 17:  c = coef_t'(4576);
            14, 16:  c = coef_t'(8684);
            15:      c = coef_t'(10411);
            default: c = '0;
        endcase
        return c;
    endfunction

    function automatic mtx_entry_t mtx_entry(input logic [MTX_W-1:0] step);
        mtx_entry_t e;
        case (step)
            3'd0:    e = '{coef: K_FRONT,  use_right: 1'b0, dst: ACC_FL};
            3'd1:    e = '{coef: K_FRONT,  use_right: 1'b1, dst: ACC_FR};
            3'd2:    e = '{coef: K_HALF,   use_right: 1'b0, dst: ACC_CN};
            3'd3:    e = '{coef: K_HALF,   use_right: 1'b1, dst: ACC_CN};
            3'd4:    e = '{coef: K_MAJOR,  use_right: 1'b0, dst: ACC_LSN};
            3'd5:    e = '{coef: -K_MINOR, use_right: 1'b1, dst: ACC_LSN};
            3'd6:    e = '{coef: K_MINOR,  use_right: 1'b0, dst: ACC_RSN};
            3'd7:    e = '{coef: -K_MAJOR, use_right: 1'b1, dst: ACC_RSN};
            default: e = '{coef: '0,       use_right: 1'b0, dst: ACC_FL};
        endcase
        return e;
    endfunction

    // round half up at q1.15, then saturate to the sample range
    function automatic sample_t round_sat(input acc_t a);
        acc_t q;
        q = (a + ROUND_BIAS) >>> Q_FRAC;
        if (q > SAT_HI)
            q = SAT_HI;
        else if (q < SAT_LO)
            q = SAT_LO;
        return sample_t'(q);
    endfunction

endpackage

// ----- hw/rtl/stsu_hist_mem.sv -----
module stsu_hist_mem
    import stsu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       rd_en,
    input  tap_idx_t   rd_addr,
    output hist_word_t rd_data,
    input  logic       wr_en,
    input  tap_idx_t   wr_addr,
    input  hist_word_t wr_data
);

    hist_word_t       mem_reg [TAPS];
    logic [TAPS-1:0]  valid_reg;
    hist_word_t       rd_data_reg;
    logic             rd_valid_reg;

    // never written entries read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
                valid_reg[wr_addr] <= 1'b1;
            if (rd_en)
                rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

// ----- hw/rtl/stsu_mac.sv -----
module stsu_mac
    import stsu_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  mac_op_t op,
    output acc_t    acc [ACC_N],
    output logic    busy
);

    prod_t    prod_reg;
    prod_t    prod_next;
    acc_idx_t prod_dst_reg;
    logic     prod_valid_reg;
    acc_t     acc_reg [ACC_N];
    acc_t     sum_next;

    assign prod_next = prod_t'(op.coef) * prod_t'(op.operand);
    assign sum_next  = acc_reg[prod_dst_reg] + acc_t'(prod_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prod_valid_reg <= 1'b0;
        else
            prod_valid_reg <= op.valid;
    end

    always_ff @(posedge clk)
    begin
        prod_reg     <= prod_next;
        prod_dst_reg <= op.dst;
        if (op.clear)
        begin
            for (int i = 0; i < ACC_N; i++)
                acc_reg[i] <= '0;
        end
        else if (prod_valid_reg)
            acc_reg[prod_dst_reg] <= sum_next;
    end

    assign acc  = acc_reg;
    assign busy = prod_valid_reg;

endmodule

// ----- hw/rtl/stereo_to_surround_upmix_unit.sv -----
// items are taken one at a time: s_axis_tready stays low from acceptance until the result is
//   loaded into the output register, since the single shared multiply-accumulate unit does
//   8 matrix products and 3*TAPS filter taps per item
// reset: rst_n asynchronous, active low; clears control, output valid and the history
//   valid bits at once, so all histories read as zero right after reset
`include "stereo_to_surround_upmix_unit_macros.svh"

module stereo_to_surround_upmix_unit
    import stsu_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // left_sample, right_sample
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // front_left, front_right, center_out, lfe_out, surround_left, surround_right
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MTX   = 3'd1;
    localparam logic [2:0] S_FIR   = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]             state_reg, state_next;
    logic [MTX_W-1:0]       step_reg, step_next;
    tap_idx_t               tap_reg, tap_next;
    lane_t                  lane_reg, lane_next;
    tap_idx_t               rd_addr_reg, rd_addr_next;
    // ptr_reg points at the oldest history entry
    tap_idx_t               ptr_reg, ptr_next;
    sample_t                left_reg, right_reg;

    // issue stage, one product per cycle
    logic                   iss_valid;
    acc_idx_t               iss_dst;
    coef_t                  iss_coef;
    logic                   iss_mem;
    logic                   iss_right;
    mtx_entry_t             mtx;

    // operand stage, lines up with the memory read data
    logic                   st1_valid_reg;
    acc_idx_t               st1_dst_reg;
    coef_t                  st1_coef_reg;
    logic                   st1_mem_reg;
    logic                   st1_right_reg;
    lane_t                  st1_lane_reg;
    sample_t                st1_operand;

    logic                   accept;
    logic                   out_free;
    logic                   load_out;
    logic                   out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;
    logic [OUT_TDATA_W-1:0] out_word;

    hist_word_t             mem_rd_data;
    hist_word_t             mem_wr_data;
    logic                   mem_rd_en;
    logic                   mem_wr_en;

    mac_op_t                mac_op;
    acc_t                   acc [ACC_N];
    logic                   mac_busy;

    sample_t                fl_q, fr_q, cn_q, lsn_q, rsn_q, cf_q, lsf_q, rsf_q;

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign load_out      = (state_reg == S_DONE) && out_free;

    // sequencer: 8 matrix steps, then 3 lanes per tap walking the history oldest first
    always_comb
    begin
        state_next   = state_reg;
        step_next    = step_reg;
        tap_next     = tap_reg;
        lane_next    = lane_reg;
        rd_addr_next = rd_addr_reg;
        ptr_next     = ptr_reg;
        iss_valid    = 1'b0;
        iss_dst      = ACC_FL;
        iss_coef     = '0;
        iss_mem      = 1'b0;
        iss_right    = 1'b0;
        mtx          = mtx_entry(step_reg);
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_MTX;
                    step_next  = '0;
                end
            end
            S_MTX:
            begin
                iss_valid = 1'b1;
                iss_dst   = mtx.dst;
                iss_coef  = mtx.coef;
                iss_right = mtx.use_right;
                if (step_reg == MTX_W'(MTX_STEPS - 1))
                begin
                    state_next   = S_FIR;
                    tap_next     = '0;
                    lane_next    = LANE_C;
                    rd_addr_next = ptr_reg;
                end
                else
                    step_next = step_reg + 1'b1;
            end
            S_FIR:
            begin
                iss_valid = 1'b1;
                iss_mem   = 1'b1;
                iss_coef  = lp_coef(tap_reg);
                case (lane_reg)
                    LANE_C:  iss_dst = ACC_CF;
                    LANE_LS: iss_dst = ACC_LSF;
                    default: iss_dst = ACC_RSF;
                endcase
                if (lane_reg == LANE_RS)
                begin
                    lane_next = LANE_C;
                    if (tap_reg == TAP_W'(TAPS - 1))
                        state_next = S_DRAIN;
                    else
                    begin
                        tap_next = tap_reg + 1'b1;
                        if (rd_addr_reg == TAP_W'(TAPS - 1))
                            rd_addr_next = '0;
                        else
                            rd_addr_next = rd_addr_reg + 1'b1;
                    end
                end
                else
                    lane_next = lane_reg + 1'b1;
            end
            S_DRAIN:
            begin
                if (!st1_valid_reg && !mac_busy)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                    if (ptr_reg == TAP_W'(TAPS - 1))
                        ptr_next = '0;
                    else
                        ptr_next = ptr_reg + 1'b1;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            tap_reg       <= '0;
            lane_reg      <= LANE_C;
            rd_addr_reg   <= '0;
            ptr_reg       <= '0;
            st1_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            tap_reg       <= tap_next;
            lane_reg      <= lane_next;
            rd_addr_reg   <= rd_addr_next;
            ptr_reg       <= ptr_next;
            st1_valid_reg <= iss_valid;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            left_reg  <= sample_t'(s_axis_tdata[SAMPLE_BITS-1:0]);
            right_reg <= sample_t'(s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]);
        end
        st1_dst_reg   <= iss_dst;
        st1_coef_reg  <= iss_coef;
        st1_mem_reg   <= iss_mem;
        st1_right_reg <= iss_right;
        st1_lane_reg  <= lane_reg;
        if (load_out)
            out_data_reg <= out_word;
    end

    // operand select: a history lane or the latched input sample
    always_comb
    begin
        if (st1_mem_reg)
        begin
            case (st1_lane_reg)
                LANE_C:  st1_operand = sample_t'(mem_rd_data[0 +: SAMPLE_BITS]);
                LANE_LS: st1_operand = sample_t'(mem_rd_data[SAMPLE_BITS +: SAMPLE_BITS]);
                default: st1_operand = sample_t'(mem_rd_data[2*SAMPLE_BITS +: SAMPLE_BITS]);
            endcase
        end
        else
            st1_operand = st1_right_reg ? right_reg : left_reg;
    end

    assign mac_op = '{clear:   accept,
                      valid:   st1_valid_reg,
                      dst:     st1_dst_reg,
                      coef:    st1_coef_reg,
                      operand: st1_operand};

    stsu_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (mac_op),
        .acc   (acc),
        .busy  (mac_busy)
    );

    // final rounding of every accumulator
    assign fl_q  = round_sat(acc[ACC_FL]);
    assign fr_q  = round_sat(acc[ACC_FR]);
    assign cn_q  = round_sat(acc[ACC_CN]);
    assign lsn_q = round_sat(acc[ACC_LSN]);
    assign rsn_q = round_sat(acc[ACC_RSN]);
    assign cf_q  = round_sat(acc[ACC_CF]);
    assign lsf_q = round_sat(acc[ACC_LSF]);
    assign rsf_q = round_sat(acc[ACC_RSF]);

    // new matrixed values replace the oldest entry once all taps are read;
    // reads and the write-back never overlap, so no forwarding is needed
    assign mem_rd_en   = (state_reg == S_FIR);
    assign mem_wr_en   = load_out;
    assign mem_wr_data = {rsn_q, lsn_q, cn_q};

    stsu_hist_mem u_hist_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (mem_rd_en),
        .rd_addr (rd_addr_reg),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (ptr_reg),
        .wr_data (mem_wr_data)
    );

    // result packing, lfe stays zero
    always_comb
    begin
        out_word = '0;
        out_word[0*SAMPLE_BITS +: SAMPLE_BITS] = fl_q;
        out_word[1*SAMPLE_BITS +: SAMPLE_BITS] = fr_q;
        out_word[2*SAMPLE_BITS +: SAMPLE_BITS] = cf_q;
        out_word[4*SAMPLE_BITS +: SAMPLE_BITS] = lsf_q;
        out_word[5*SAMPLE_BITS +: SAMPLE_BITS] = rsf_q;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // the mac pipeline is empty whenever a new item can come in
    `STSU_ASSERT_SAME(a_idle_drained, s_axis_tready, !st1_valid_reg && !mac_busy, "mac busy while idle")
    // an accepted item starts the matrix steps from the first one
    `STSU_ASSERT_NEXT(a_accept_starts, accept, (state_reg == S_MTX) && (step_reg == '0), "bad start")
    // history write-back only after every tap product has landed
    `STSU_ASSERT_SAME(a_wb_drained, mem_wr_en, !st1_valid_reg && !mac_busy && !mem_rd_en, "early write")

endmodule
